[hw/rtl/stm_pkg.sv]
// Shared types and constants of the task-to-worker block map.
`default_nettype none

package stm_pkg;

   // field widths
   localparam int TASK_W    = 13;   // task counts and task_count register
   localparam int WORKER_W  = 11;   // worker_count register
   localparam int IDX_W     = 10;   // worker index on the result
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = TASK_W;

   localparam logic [TASK_W-1:0]   MAX_TASKS   = 13'd4096;
   localparam logic [WORKER_W-1:0] MAX_WORKERS = 11'd1024;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_TASK  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_COUNT = 1'b1;

   // shared divider
   localparam int DIVIDEND_W = TASK_W;
   localparam int DIVISOR_W  = WORKER_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_BASE,
      ST_DIV_GAP,
      ST_ENTER,
      ST_STEP
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/stm_req_if.sv]
// Request channel: valid/ready handshake carrying the restart flag.
`default_nettype none

interface stm_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

[hw/rtl/stm_rsp_if.sv]
// Result channel: valid/ready handshake carrying worker index, last flag and status.
`default_nettype none

interface stm_rsp_if;
   import stm_pkg::*;

   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    worker_index;
   logic                last_task;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output worker_index, output last_task, output status,
                   input ready);
   modport sink   (input valid, input worker_index, input last_task, input status,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/stm_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module stm_div (
   input  logic                clock,
   input  logic                reset,
   input  stm_pkg::div_req_type div_req,
   output stm_pkg::div_rsp_type div_rsp
);
   import stm_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0] divisor_ff;

   logic [DIVISOR_W+1:0] trial;
   logic                 fits;

   // shift in the next dividend bit and try to subtract
   assign trial = {1'b0, rem_ff, quo_ff[DIVIDEND_W-1]} - {2'b00, divisor_ff};
   assign fits  = ~trial[DIVISOR_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start && !busy_ff) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(DIV_STEPS - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start && !busy_ff) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DIVISOR_W-1:0] : {rem_ff[DIVISOR_W-2:0], quo_ff[DIVIDEND_W-1]};
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff == '0) |=> done_ff)
      else $error("divider missed its done pulse");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (done_ff && divisor_ff != '0) |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[hw/rtl/spread_block_task_to_worker_map.sv]
// Top level: sequencer and task map state of the task-to-worker block map.
// A next-task request is accepted only while idle; its result is registered in the STEP
//   state when the result register is free, before a new request is taken. A valid
//   restart runs one or two divisions on the shared divider, the second with leftover tasks.
// Request ready is high whenever the sequencer is idle, also while a result waits.
// Reset (synchronous, active high) clears both registers and all map state; a restart
//   is needed before the first next-task request.
`default_nettype none

module spread_block_task_to_worker_map (
   input  logic                               clock,
   input  logic                               reset,
   stm_req_if.sink                            req,
   stm_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [stm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import stm_pkg::*;

   // configuration
   logic [TASK_W-1:0]   task_count_ff;
   logic [WORKER_W-1:0] worker_count_ff;

   // sequencer
   state_type           state_ff, state_in;
   logic                restart_ff, restart_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   // map state
   logic [IDX_W-1:0]    current_worker_ff, current_worker_in;
   logic [TASK_W-1:0]   left_in_worker_ff, left_in_worker_in;
   logic [TASK_W-1:0]   tasks_issued_ff, tasks_issued_in;
   logic [TASK_W-1:0]   base_share_ff, base_share_in;
   logic [IDX_W-1:0]    gap_ff, gap_in;             // free workers per leftover
   logic [IDX_W-1:0]    wide_total_ff, wide_total_in;
   logic [IDX_W-1:0]    wide_used_ff, wide_used_in;
   logic [WORKER_W-1:0] next_extra_ff, next_extra_in;
   logic                extras_pending_ff, extras_pending_in;
   logic                sequence_valid_ff, sequence_valid_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_worker_ff, rsp_worker_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                req_fire;
   logic                out_free;
   logic [STATUS_W-1:0] cfg_err;

   // worker entry: make enter_w current and load its block size
   logic [IDX_W-1:0]    enter_w;
   logic                enter_is_extra;
   logic                enter_wide;
   logic [WORKER_W-1:0] enter_step;
   logic [WORKER_W:0]   enter_next;

   // per-task step
   logic [TASK_W-1:0]   issued_next;
   logic                step_last;
   logic [TASK_W-1:0]   left_dec;
   logic [WORKER_W-1:0] worker_plus;
   logic                advance;
   logic [STATUS_W-1:0] step_status;

   stm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.worker_index = rsp_worker_ff;
   assign rsp.last_task    = rsp_last_ff;
   assign rsp.status       = rsp_status_ff;

   // configuration checks done at restart, in the order of precedence
   always_comb begin
      if (worker_count_ff == '0 || worker_count_ff > MAX_WORKERS || task_count_ff > MAX_TASKS)
      begin
         cfg_err = STATUS_NO_TASK;
      end else if ({{(TASK_W-WORKER_W){1'b0}}, worker_count_ff} > task_count_ff) begin
         cfg_err = STATUS_TOO_MANY;
      end else begin
         cfg_err = STATUS_OK;
      end
   end

   // step arithmetic
   assign issued_next = tasks_issued_ff + 1'b1;
   assign step_last   = (issued_next == task_count_ff);
   assign left_dec    = (left_in_worker_ff != '0) ? left_in_worker_ff - 1'b1 : '0;
   assign worker_plus = {1'b0, current_worker_ff} + 1'b1;
   assign advance     = (left_dec == '0) && !step_last && (worker_plus < worker_count_ff);

   always_comb begin
      if (err_ff != STATUS_OK) begin
         step_status = err_ff;
      end else if (!restart_ff && (!sequence_valid_ff || tasks_issued_ff >= task_count_ff))
      begin
         step_status = STATUS_NO_TASK;
      end else begin
         step_status = STATUS_OK;
      end
   end

   // worker entry arithmetic; extras land every 1+gap workers, first wide_total gaps wider
   assign enter_w        = (state_ff == ST_ENTER) ? '0 : worker_plus[IDX_W-1:0];
   assign enter_is_extra = extras_pending_ff && ({1'b0, enter_w} == next_extra_ff);
   assign enter_wide     = (wide_used_ff < wide_total_ff);
   assign enter_step     = WORKER_W'(1) + {1'b0, gap_ff} + {{(WORKER_W-1){1'b0}}, enter_wide};
   assign enter_next     = {2'b00, enter_w} + {1'b0, enter_step};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req.restart && cfg_err == STATUS_OK) ? ST_DIV_BASE : ST_STEP;
            end
         end
         ST_DIV_BASE: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.remainder != '0) ? ST_DIV_GAP : ST_ENTER;
            end
         end
         ST_DIV_GAP: begin
            if (div_rsp.done) begin
               state_in = ST_ENTER;
            end
         end
         ST_ENTER: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      restart_in        = restart_ff;
      err_in            = err_ff;
      current_worker_in = current_worker_ff;
      left_in_worker_in = left_in_worker_ff;
      tasks_issued_in   = tasks_issued_ff;
      base_share_in     = base_share_ff;
      gap_in            = gap_ff;
      wide_total_in     = wide_total_ff;
      wide_used_in      = wide_used_ff;
      next_extra_in     = next_extra_ff;
      extras_pending_in = extras_pending_ff;
      sequence_valid_in = sequence_valid_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_worker_in     = rsp_worker_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_status_in     = rsp_status_ff;
      div_req.start     = 1'b0;
      div_req.dividend  = task_count_ff;
      div_req.divisor   = worker_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               restart_in = req.restart;
               err_in     = req.restart ? cfg_err : STATUS_OK;
               if (req.restart) begin
                  sequence_valid_in = 1'b0;
                  div_req.start     = (cfg_err == STATUS_OK);
               end
            end
         end
         ST_DIV_BASE: begin
            if (div_rsp.done) begin
               base_share_in   = div_rsp.quotient;
               wide_used_in    = '0;
               next_extra_in   = '0;
               tasks_issued_in = '0;
               gap_in          = '0;
               wide_total_in   = '0;
               extras_pending_in = (div_rsp.remainder != '0);
               // second pass: free workers over leftovers
               div_req.start    = (div_rsp.remainder != '0);
               div_req.dividend = {{(DIVIDEND_W-WORKER_W){1'b0}},
                                   worker_count_ff - div_rsp.remainder};
               div_req.divisor  = div_rsp.remainder;
            end
         end
         ST_DIV_GAP: begin
            if (div_rsp.done) begin
               gap_in        = div_rsp.quotient[IDX_W-1:0];
               wide_total_in = div_rsp.remainder[IDX_W-1:0];
            end
         end
         ST_ENTER: begin
            sequence_valid_in = 1'b1;
         end
         ST_STEP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = step_status;
               rsp_worker_in = '0;
               rsp_last_in   = 1'b0;
               if (step_status == STATUS_OK) begin
                  rsp_worker_in     = current_worker_ff;
                  rsp_last_in       = step_last;
                  tasks_issued_in   = issued_next;
                  left_in_worker_in = left_dec;
               end
            end
         end
         default: begin
         end
      endcase

      // enter first worker after the split, or the next one when a block runs out
      if ((state_ff == ST_ENTER) ||
          (state_ff == ST_STEP && out_free && step_status == STATUS_OK && advance)) begin
         current_worker_in = enter_w;
         left_in_worker_in = base_share_ff + {{(TASK_W-1){1'b0}}, enter_is_extra};
         if (enter_is_extra) begin
            if (enter_wide) begin
               wide_used_in = wide_used_ff + 1'b1;
            end
            next_extra_in     = enter_next[WORKER_W-1:0];
            extras_pending_in = (enter_next < {1'b0, worker_count_ff});
         end
      end

      // any register write drops the running sequence
      if (csr_write_enable) begin
         sequence_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff   <= '0;
         worker_count_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TASK_COUNT:   task_count_ff   <= csr_write_data;
            CSR_WORKER_COUNT: worker_count_ff <= csr_write_data[WORKER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         restart_ff        <= 1'b0;
         err_ff            <= STATUS_OK;
         current_worker_ff <= '0;
         left_in_worker_ff <= '0;
         tasks_issued_ff   <= '0;
         base_share_ff     <= '0;
         gap_ff            <= '0;
         wide_total_ff     <= '0;
         wide_used_ff      <= '0;
         next_extra_ff     <= '0;
         extras_pending_ff <= 1'b0;
         sequence_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         restart_ff        <= restart_in;
         err_ff            <= err_in;
         current_worker_ff <= current_worker_in;
         left_in_worker_ff <= left_in_worker_in;
         tasks_issued_ff   <= tasks_issued_in;
         base_share_ff     <= base_share_in;
         gap_ff            <= gap_in;
         wide_total_ff     <= wide_total_in;
         wide_used_ff      <= wide_used_in;
         next_extra_ff     <= next_extra_in;
         extras_pending_ff <= extras_pending_in;
         sequence_valid_ff <= sequence_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_worker_ff <= rsp_worker_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_worker_ff == '0 && !rsp_last_ff))
      else $error("error result carries a worker or last flag");

   a_fresh_sequence: assert property (@(posedge clock) disable iff (reset)
      $rose(sequence_valid_ff) |-> (tasks_issued_ff == '0 && current_worker_ff == '0))
      else $error("sequence started away from the first task");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_worker_ff) &&
                                        $stable(rsp_last_ff) && $stable(rsp_status_ff)))
      else $error("result changed while waiting");

endmodule

`default_nettype wire
